/* rtl/interleaved_block_code_codec_top_assert.svh */
// ---------------------------------------------------------------------------
// Interleaved block code codec assertion macros
// Shared concurrent assertion forms for the codec RTL.
// ---------------------------------------------------------------------------
`ifndef INTERLEAVED_BLOCK_CODE_CODEC_TOP_ASSERT_SVH
`define INTERLEAVED_BLOCK_CODE_CODEC_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IBCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("codec assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define IBCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("codec assertion failed: next-cycle implication");

`endif

/* rtl/ibcc_pkg.sv */
// ---------------------------------------------------------------------------
// Interleaved block code codec package
// Widths, command codes and the item and result types shared by the codec.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibcc_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 60;
    localparam int TDATA_W = 72;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [BYTE_W-1:0]  message_byte;
        logic [WORD_W-1:0]  received_word;
    } item_t;

    typedef struct packed
    {
        logic [WORD_W-1:0]  code_word;
        logic [BYTE_W-1:0]  decoded_byte;
    } result_t;

endpackage

`default_nettype wire

/* rtl/interleaved_block_code_codec_top.sv */
// ---------------------------------------------------------------------------
// Interleaved block code codec
// Streaming encoder and decoder for an interleaved four-symbol block code.
// ---------------------------------------------------------------------------
// Usage:
// Each beat on the s_axis side carries one command in s_axis_tuser. Encode
// turns message_byte into a 60-bit interleaved codeword; decode takes a
// 60-bit received word and returns the nearest-codeword byte. Every input
// beat produces exactly one m_axis beat, in order; the field not produced by
// the command reads as zero.
// An accepted beat passes through one input register and the single-pass
// codec logic into the result register, which drives m_axis_tvalid.
// Throughput is one beat per cycle while the receiver does not stall, set by
// the single-pass core between the two registers.
// Reset empties both stages; no beat is presented until a new one arrives.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; s_axis_tready drops only when both
// stages are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "interleaved_block_code_codec_top_assert.svh"

module interleaved_block_code_codec_top
(
    input  wire                             clk,
    input  wire                             rst_n,

    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: message_byte[7:0], received_word[67:8], zero pad.
    input  wire [ibcc_pkg::TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: cmd[0].
    input  wire                             s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // Fields from bit 0: code_word[59:0], decoded_byte[67:60], zero pad.
    output logic [ibcc_pkg::TDATA_W-1:0]    m_axis_tdata
);

    localparam int PAD_W = ibcc_pkg::TDATA_W - ibcc_pkg::WORD_W - ibcc_pkg::BYTE_W;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    ibcc_pkg::item_t    s1_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    ibcc_pkg::result_t  res_reg;
    ibcc_pkg::result_t  core_result;

    logic               in_accept;
    logic               out_free;
    logic               s1_adv;
    logic               res_one_field;
    logic               both_full_stalled;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.cmd           <= ibcc_pkg::cmd_t'(s_axis_tuser);
            s1_item_reg.message_byte  <= s_axis_tdata[ibcc_pkg::BYTE_W-1:0];
            s1_item_reg.received_word <=
                s_axis_tdata[ibcc_pkg::BYTE_W +: ibcc_pkg::WORD_W];
        end
        if (s1_adv)
        begin
            res_reg <= core_result;
        end
    end

    ibcc_core u_core
    (
        .item   (s1_item_reg),
        .result (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, res_reg.decoded_byte, res_reg.code_word};

    assign res_one_field     = (res_reg.code_word == '0) || (res_reg.decoded_byte == '0);
    assign both_full_stalled = s1_valid_reg && out_valid_reg && !m_axis_tready;

    // A result carries either a codeword or a decoded byte, never both.
    `IBCC_ASSERT_IMP(a_one_field_live, clk, rst_n, out_valid_reg, res_one_field)
    `IBCC_ASSERT_IMP(a_full_blocks_input, clk, rst_n, both_full_stalled, !s_axis_tready)
    `IBCC_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_accept, s1_valid_reg)
    `IBCC_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, s1_adv, out_valid_reg)

endmodule

`default_nettype wire

/* rtl/ibcc_core.sv */
// ---------------------------------------------------------------------------
// Interleaved block code codec core
// Single-pass encode or nearest-codeword decode of one item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibcc_core
(
    input  var ibcc_pkg::item_t   item,
    output ibcc_pkg::result_t     result
);

    typedef logic [14:0] chunk_t;

    localparam chunk_t CODE_TABLE [4] = '{15'h0000, 15'h3333, 15'h5555, 15'h6666};

    // Bit 10r+j of the plain word moves to bit 6j+r of the line word.
    function automatic logic [ibcc_pkg::WORD_W-1:0] spread_bits(
        input logic [ibcc_pkg::WORD_W-1:0] w);
        logic [ibcc_pkg::WORD_W-1:0] o;
        o = '0;
        for (int r = 0; r < 6; r++)
        begin
            for (int j = 0; j < 10; j++)
            begin
                o[6*j+r] = w[10*r+j];
            end
        end
        return o;
    endfunction

    function automatic logic [ibcc_pkg::WORD_W-1:0] gather_bits(
        input logic [ibcc_pkg::WORD_W-1:0] w);
        logic [ibcc_pkg::WORD_W-1:0] o;
        o = '0;
        for (int r = 0; r < 6; r++)
        begin
            for (int j = 0; j < 10; j++)
            begin
                o[10*r+j] = w[6*j+r];
            end
        end
        return o;
    endfunction

    function automatic logic [3:0] popcount15(input chunk_t v);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 15; k++)
        begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    // A strict less-than keeps the lowest symbol on equal distances.
    function automatic logic [1:0] decode_chunk(input chunk_t c);
        logic [3:0] chunk_dist [4];
        logic [3:0] best_d;
        logic [1:0] best;
        for (int s = 0; s < 4; s++)
        begin
            chunk_dist[s] = popcount15(c ^ CODE_TABLE[s]);
        end
        best   = 2'd0;
        best_d = chunk_dist[0];
        for (int s = 1; s < 4; s++)
        begin
            if (chunk_dist[s] < best_d)
            begin
                best_d = chunk_dist[s];
                best   = 2'(s);
            end
        end
        return best;
    endfunction

    logic [ibcc_pkg::WORD_W-1:0] enc_plain;
    logic [ibcc_pkg::WORD_W-1:0] dec_plain;
    logic [ibcc_pkg::BYTE_W-1:0] dec_byte;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            enc_plain[15*i +: 15] = CODE_TABLE[item.message_byte[2*i +: 2]];
        end
    end

    assign dec_plain = gather_bits(item.received_word);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dec_byte[2*i +: 2] = decode_chunk(dec_plain[15*i +: 15]);
        end
    end

    always_comb
    begin
        unique case (item.cmd)
            ibcc_pkg::CMD_ENCODE:
            begin
                result.code_word    = spread_bits(enc_plain);
                result.decoded_byte = '0;
            end
            ibcc_pkg::CMD_DECODE:
            begin
                result.code_word    = '0;
                result.decoded_byte = dec_byte;
            end
            default:
            begin
                result.code_word    = '0;
                result.decoded_byte = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// Interleaved block code codec testbench
// Streams a mix of encode and decode commands into the codec under random
// idling on both sides, including one long receiver hold-off. Each output
// beat is checked field by field against a local model of the interleaved
// four-symbol block code.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_REPORTS  = 20;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0: message_byte[7:0], received_word[67:8], zero pad.
    logic [ibcc_pkg::TDATA_W-1:0] s_axis_tdata = '0;
    // Fields from bit 0: cmd[0].
    logic                 s_axis_tuser = 1'b0;

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0: code_word[59:0], decoded_byte[67:60], zero pad.
    logic [ibcc_pkg::TDATA_W-1:0] m_axis_tdata;

    ibcc_pkg::item_t      pending_items[$];
    ibcc_pkg::result_t    expected_results[$];
    ibcc_pkg::item_t      offered_item;
    ibcc_pkg::result_t    want_result;

    int                   error_count = 0;
    int                   items_accepted = 0;
    int                   beats_seen = 0;
    int                   send_gap = 0;
    int                   recv_stall = 0;
    logic                 hold_off = 1'b0;

    interleaved_block_code_codec_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Code model
    // -----------------------------------------------------------------------

    function automatic logic [14:0] symbol_codeword(input logic [1:0] sym);
        case (sym)
            2'd0:    return 15'h0000;
            2'd1:    return 15'h3333;
            2'd2:    return 15'h5555;
            default: return 15'h6666;
        endcase
    endfunction

    // Bit 10r+j moves to bit 6j+r.
    function automatic logic [ibcc_pkg::WORD_W-1:0] interleave(
        input logic [ibcc_pkg::WORD_W-1:0] w);
        logic [ibcc_pkg::WORD_W-1:0] o;
        o = '0;
        for (int r = 0; r < 6; r++)
            for (int j = 0; j < 10; j++)
                o[6*j + r] = w[10*r + j];
        return o;
    endfunction

    function automatic logic [ibcc_pkg::WORD_W-1:0] deinterleave(
        input logic [ibcc_pkg::WORD_W-1:0] w);
        logic [ibcc_pkg::WORD_W-1:0] o;
        o = '0;
        for (int r = 0; r < 6; r++)
            for (int j = 0; j < 10; j++)
                o[10*r + j] = w[6*j + r];
        return o;
    endfunction

    function automatic logic [ibcc_pkg::WORD_W-1:0] encode_byte(
        input logic [ibcc_pkg::BYTE_W-1:0] msg);
        logic [ibcc_pkg::WORD_W-1:0] plain;
        plain = '0;
        for (int i = 0; i < 4; i++)
            plain[15*i +: 15] = symbol_codeword(msg[2*i +: 2]);
        return interleave(plain);
    endfunction

    // Nearest codeword per chunk; on equal distance the lower symbol is kept.
    function automatic logic [ibcc_pkg::BYTE_W-1:0] decode_word(
        input logic [ibcc_pkg::WORD_W-1:0] rx);
        logic [ibcc_pkg::WORD_W-1:0] plain;
        logic [14:0]                 diff;
        logic [ibcc_pkg::BYTE_W-1:0] out;
        int                          best;
        int                          best_dist;
        int                          sym_dist;
        plain = deinterleave(rx);
        out = '0;
        for (int i = 0; i < 4; i++)
        begin
            best = 0;
            best_dist = 16;
            for (int s = 0; s < 4; s++)
            begin
                diff = plain[15*i +: 15] ^ symbol_codeword(s[1:0]);
                sym_dist = 0;
                for (int k = 0; k < 15; k++)
                    sym_dist += diff[k];
                if (sym_dist < best_dist)
                begin
                    best_dist = sym_dist;
                    best = s;
                end
            end
            out[2*i +: 2] = best[1:0];
        end
        return out;
    endfunction

    function automatic ibcc_pkg::result_t codec_result(input ibcc_pkg::item_t it);
        ibcc_pkg::result_t res;
        res = '0;
        if (it.cmd == ibcc_pkg::CMD_ENCODE)
            res.code_word = encode_byte(it.message_byte);
        else
            res.decoded_byte = decode_word(it.received_word);
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    function automatic ibcc_pkg::item_t make_item(input ibcc_pkg::cmd_t cmd,
                                                  input logic [ibcc_pkg::BYTE_W-1:0] msg,
                                                  input logic [ibcc_pkg::WORD_W-1:0] word);
        ibcc_pkg::item_t it;
        it.cmd = cmd;
        it.message_byte = msg;
        it.received_word = word;
        return it;
    endfunction

    function automatic logic [ibcc_pkg::WORD_W-1:0] random_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ibcc_pkg::WORD_W-1:0];
    endfunction

    function automatic logic [ibcc_pkg::WORD_W-1:0] flip_bits(
        input logic [ibcc_pkg::WORD_W-1:0] w, input int n);
        for (int k = 0; k < n; k++)
            w[$urandom_range(0, ibcc_pkg::WORD_W-1)] ^= 1'b1;
        return w;
    endfunction

    // No idling while the receiver is held off, and in some quiet windows.
    function automatic int idle_length();
        int pick;
        if (hold_off || ((items_accepted / 128) % 5 == 2))
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // -----------------------------------------------------------------------
    // Driver
    // -----------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(codec_result(offered_item));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    offered_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0, offered_item.received_word,
                                     offered_item.message_byte};
                    s_axis_tuser <= offered_item.cmd;
                    send_gap = idle_length();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor
    // -----------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", m_axis_tdata[63:0], 64'h0);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (m_axis_tdata[59:0] !== want_result.code_word)
                        report_mismatch("code_word", 64'(m_axis_tdata[59:0]),
                                        64'(want_result.code_word));
                    if (m_axis_tdata[67:60] !== want_result.decoded_byte)
                        report_mismatch("decoded_byte", 64'(m_axis_tdata[67:60]),
                                        64'(want_result.decoded_byte));
                end
            end
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_stall = idle_length();
            end
        end
    end

    // Long receiver hold-off so that both pipeline stages fill and the input
    // side stalls while the sender keeps offering beats.
    initial
    begin
        while (items_accepted < 300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------

    initial
    begin
        logic [ibcc_pkg::BYTE_W-1:0] msg;
        int                          pick;

        // Encode: extremes, every symbol in every slot, garbage in the unused word.
        pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, 8'h00, '0));
        pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, 8'hFF, '1));
        pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, 8'h1B, random_word()));
        pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, 8'hE4, random_word()));
        pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, 8'h55,
                                          60'hA5A5A5A5A5A5A5A));
        pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, 8'hAA,
                                          60'h5A5A5A5A5A5A5A5));

        // Decode: all zeros and all ones, clean codewords with garbage in the
        // unused byte, then corrupted codewords.
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'hFF, '0));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h00, '1));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'hC3, encode_byte(8'h1B)));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h3C, encode_byte(8'hE4)));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h00,
                                          encode_byte(8'hFF) ^ 60'h1));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h00,
                                          encode_byte(8'h93) ^ (60'h1 << 59)));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h00,
                                          flip_bits(encode_byte(8'h6C), 3)));

        // Equal distances: a chunk halfway between the first two codewords,
        // one halfway between the first and third, and two that sit at the same
        // distance from the three nonzero codewords.
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h00,
            interleave({15'h7FFF, 15'h7777, 15'h0055, 15'h0033})));
        pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'h00,
            interleave({15'h0033, 15'h0055, 15'h7777, 15'h7FFF})));

        // Random part: codewords with a few bit errors as the largest share, plus
        // clean encodes and raw noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            msg = 8'($urandom);
            if (pick < 35)
                pending_items.push_back(make_item(ibcc_pkg::CMD_ENCODE, msg,
                                                  random_word()));
            else if (pick < 80)
                pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'($urandom),
                    flip_bits(encode_byte(msg), $urandom_range(0, 8))));
            else
                pending_items.push_back(make_item(ibcc_pkg::CMD_DECODE, 8'($urandom),
                                                  random_word()));
        end

        @(posedge rst_n);
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() > 0)
            report_mismatch("results never delivered", 64'(expected_results.size()),
                            64'h0);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ibcc_pkg.sv
rtl/ibcc_core.sv
rtl/interleaved_block_code_codec_top.sv
tb/tb.sv
